@@ hdl/lacc_pkg.sv @@
// Shared types and constants of the life automaton with cell counters.
// Used by the top level, the rule unit and the testbench; no dependencies.
package lacc_pkg;

    // Item modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_ADVANCE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // Configuration register index, taken from paddr[2]
    localparam logic       REG_BOARD_SIDE   = 1'b0;
    localparam logic [6:0] BOARD_SIDE_RESET = 7'd64;

    // B3/S23 neighbor sums
    localparam logic [3:0] BIRTH_SUM  = 4'd3;
    localparam logic [3:0] CROWD_SUM  = 4'd4;
    localparam logic [3:0] LONELY_SUM = 4'd1;

    // Bit positions of one window column: row above, own row, row below
    localparam int COL_TOP = 2;
    localparam int COL_MID = 1;
    localparam int COL_BOT = 0;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ADV   = 4'b0100,
        S_RES   = 4'b1000
    } t_state;

    // Decision of the rule unit for one cell
    typedef struct packed {
        logic next_alive;
        logic bump_alive;
        logic bump_surv;
    } t_rule_ctl;

endpackage

@@ hdl/life_automaton_with_cell_counters_core.sv @@
// Top level of the life automaton with per-cell alive and survival counters.
// Depends on lacc_pkg, lacc_ram and lacc_rule.
//
//  channel   direction  handshake                       payload
//  request   in         i_in_valid / o_in_ready         i_mode i_row i_column i_alive_in
//  result    out        o_out_valid / i_out_ready       o_alive_out o_alive_generations
//                                                       o_survived_generations
//  config    in         psel penable pwrite / pready    paddr pwdata prdata
//
// Load, read and unused-mode requests go straight to the result state, which loads
// the output register and returns to idle.
// Advance sweeps the square row by row: the rule unit handles one cell
// per cycle, plus one flush column per row, limited by one board read port per copy.
// After reset a clearing pass over all 2**(2*ceil(log2(MAX_SIDE))) addresses (4096 at 64)
// zeroes the board and counters; no request is taken meanwhile, config writes are.
// A stalled result holds in the output register; the next request is still taken.
module life_automaton_with_cell_counters_core import lacc_pkg::*; #(
    parameter int MAX_SIDE    = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_mode,
    input  logic [5:0]             i_row,
    input  logic [5:0]             i_column,
    input  logic                   i_alive_in,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_alive_out,
    output logic [COUNT_WIDTH-1:0] o_alive_generations,
    output logic [COUNT_WIDTH-1:0] o_survived_generations,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW     = $clog2(MAX_SIDE);
    localparam int CW     = $clog2(MAX_SIDE + 1);
    localparam int BW     = 2 * AW;
    localparam int BDEPTH = 1 << BW;
    localparam int LDEPTH = 1 << AW;

    // Control state
    t_state            r_state, n_state;
    logic [BW-1:0]     r_clr, n_clr;
    logic [AW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_fcol, n_fcol;
    logic              r_fetch_done, n_fetch_done;
    logic              r_res_read, n_res_read;
    logic              r_s1_valid;
    logic [6:0]        r_board_side;

    // Arrival stage payload and window
    logic [AW-1:0]     r_s1_row;
    logic [CW-1:0]     r_s1_col;
    logic              r_s1_flush;
    logic              r_s1_top_ok;
    logic              r_s1_bot_ok;
    logic [2:0]        r_w1;
    logic [2:0]        r_w2;

    // Datapath wires
    logic [CW-1:0]     side_n;
    logic              in_acc;
    logic              in_inside;
    logic [BW-1:0]     in_addr;
    logic              fetch_go;
    logic              f_flush;
    logic              f_last_row;
    logic              f_bot_ok;
    logic [CW-1:0]     f_prev;
    logic [AW-1:0]     f_row_next;
    logic [CW-1:0]     s1_prev;
    logic              eval_go;
    logic [BW-1:0]     eval_addr;
    logic [2:0]        x_col;
    t_rule_ctl         rule_ctl;
    logic [COUNT_WIDTH-1:0] rule_acnt;
    logic [COUNT_WIDTH-1:0] rule_scnt;

    // Memory ports
    logic              brd_we;
    logic [BW-1:0]     brd_waddr;
    logic              brd_wdata;
    logic              brd_a_re;
    logic [BW-1:0]     brd_a_raddr;
    logic              brd_a_rd;
    logic              brd_b_re;
    logic [BW-1:0]     brd_b_raddr;
    logic              brd_b_rd;
    logic              acnt_we;
    logic [COUNT_WIDTH-1:0] acnt_wdata;
    logic              scnt_we;
    logic [COUNT_WIDTH-1:0] scnt_wdata;
    logic [BW-1:0]     cnt_waddr;
    logic              cnt_re;
    logic [BW-1:0]     cnt_raddr;
    logic [COUNT_WIDTH-1:0] acnt_rd;
    logic [COUNT_WIDTH-1:0] scnt_rd;
    logic              line_we;
    logic [AW-1:0]     line_waddr;
    logic              line_rd;

    // Clamp the configured side to the board
    always_comb begin
        if (32'(r_board_side) > MAX_SIDE) begin
            side_n = CW'(MAX_SIDE);
        end else begin
            side_n = CW'(r_board_side);
        end
    end

    // Request decode
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_inside  = (32'(i_row) < 32'(side_n)) && (32'(i_column) < 32'(side_n));
    assign in_addr    = {AW'(i_row), AW'(i_column)};

    // Fetch position of the sweep
    assign fetch_go   = (r_state == S_ADV) && !r_fetch_done;
    assign f_flush    = (r_fcol == side_n);
    assign f_last_row = (32'(r_row) + 1 == 32'(side_n));
    assign f_bot_ok   = (32'(r_row) + 1 < 32'(side_n));
    assign f_prev     = r_fcol - CW'(1);
    assign f_row_next = r_row + AW'(1);

    // Arrival: build the new window column, masked at the board edges
    assign s1_prev   = r_s1_col - CW'(1);
    assign eval_go   = r_s1_valid && (r_s1_col != '0);
    assign eval_addr = {r_s1_row, s1_prev[AW-1:0]};
    assign x_col[COL_TOP] = r_s1_top_ok && line_rd && !r_s1_flush;
    assign x_col[COL_MID] = brd_a_rd && !r_s1_flush;
    assign x_col[COL_BOT] = r_s1_bot_ok && brd_b_rd && !r_s1_flush;

    lacc_rule #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_rule (
        .i_w1   (r_w1),
        .i_w2   (r_w2),
        .i_x    (x_col),
        .i_acnt (acnt_rd),
        .i_scnt (scnt_rd),
        .o_ctl  (rule_ctl),
        .o_acnt (rule_acnt),
        .o_scnt (rule_scnt)
    );

    // Select the write source: clearing pass, load, or rule result
    always_comb begin
        brd_we     = 1'b0;
        brd_waddr  = eval_addr;
        brd_wdata  = rule_ctl.next_alive;
        acnt_we    = 1'b0;
        acnt_wdata = rule_acnt;
        scnt_we    = 1'b0;
        scnt_wdata = rule_scnt;
        cnt_waddr  = eval_addr;
        if (r_state == S_CLEAR) begin
            brd_we     = 1'b1;
            brd_waddr  = r_clr;
            brd_wdata  = 1'b0;
            acnt_we    = 1'b1;
            acnt_wdata = '0;
            scnt_we    = 1'b1;
            scnt_wdata = '0;
            cnt_waddr  = r_clr;
        end else if (in_acc && (i_mode == MODE_LOAD) && in_inside) begin
            brd_we     = 1'b1;
            brd_waddr  = in_addr;
            brd_wdata  = i_alive_in;
            acnt_we    = 1'b1;
            acnt_wdata = COUNT_WIDTH'(i_alive_in);
            scnt_we    = 1'b1;
            scnt_wdata = '0;
            cnt_waddr  = in_addr;
        end else if (eval_go) begin
            brd_we     = 1'b1;
            acnt_we    = rule_ctl.bump_alive;
            scnt_we    = rule_ctl.bump_surv;
        end
    end

    // Select the read source: sweep fetch or a read request
    assign brd_a_re    = fetch_go || (in_acc && (i_mode == MODE_READ));
    assign brd_a_raddr = fetch_go ? {r_row, r_fcol[AW-1:0]} : in_addr;
    assign brd_b_re    = fetch_go;
    assign brd_b_raddr = {f_row_next, r_fcol[AW-1:0]};
    assign cnt_re      = brd_a_re;
    assign cnt_raddr   = fetch_go ? {r_row, f_prev[AW-1:0]} : in_addr;

    // Keep the old row for the row below
    assign line_we    = r_s1_valid && !r_s1_flush;
    assign line_waddr = r_s1_col[AW-1:0];

    // Two board copies give two reads per cycle
    lacc_ram #(.WIDTH(1), .DEPTH(BDEPTH)) u_board_a (
        .i_clk   (i_clk),
        .i_we    (brd_we),
        .i_waddr (brd_waddr),
        .i_wdata (brd_wdata),
        .i_re    (brd_a_re),
        .i_raddr (brd_a_raddr),
        .o_rdata (brd_a_rd)
    );

    lacc_ram #(.WIDTH(1), .DEPTH(BDEPTH)) u_board_b (
        .i_clk   (i_clk),
        .i_we    (brd_we),
        .i_waddr (brd_waddr),
        .i_wdata (brd_wdata),
        .i_re    (brd_b_re),
        .i_raddr (brd_b_raddr),
        .o_rdata (brd_b_rd)
    );

    lacc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BDEPTH)) u_alive_cnt (
        .i_clk   (i_clk),
        .i_we    (acnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (acnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (acnt_rd)
    );

    lacc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BDEPTH)) u_surv_cnt (
        .i_clk   (i_clk),
        .i_we    (scnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (scnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (scnt_rd)
    );

    lacc_ram #(.WIDTH(1), .DEPTH(LDEPTH)) u_row_above (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (brd_a_rd),
        .i_re    (fetch_go),
        .i_raddr (r_fcol[AW-1:0]),
        .o_rdata (line_rd)
    );

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_row        = r_row;
        n_fcol       = r_fcol;
        n_fetch_done = r_fetch_done;
        n_res_read   = r_res_read;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + BW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res_read   = (i_mode == MODE_READ) && in_inside;
                    n_row        = '0;
                    n_fcol       = '0;
                    n_fetch_done = 1'b0;
                    if ((i_mode == MODE_ADVANCE) && (side_n != '0)) begin
                        n_state = S_ADV;
                    end else begin
                        n_state = S_RES;
                    end
                end
            end
            S_ADV: begin
                if (fetch_go) begin
                    if (f_flush) begin
                        n_fcol = '0;
                        if (f_last_row) begin
                            n_fetch_done = 1'b1;
                        end else begin
                            n_row = f_row_next;
                        end
                    end else begin
                        n_fcol = r_fcol + CW'(1);
                    end
                end else if (!r_s1_valid) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (!o_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_row        <= '0;
            r_fcol       <= '0;
            r_fetch_done <= 1'b1;
            r_res_read   <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_row        <= n_row;
            r_fcol       <= n_fcol;
            r_fetch_done <= n_fetch_done;
            r_res_read   <= n_res_read;
            r_s1_valid   <= fetch_go;
        end
    end

    // Arrival stage payload and window shift
    always_ff @(posedge i_clk) begin
        if (fetch_go) begin
            r_s1_row    <= r_row;
            r_s1_col    <= r_fcol;
            r_s1_flush  <= f_flush;
            r_s1_top_ok <= (r_row != '0);
            r_s1_bot_ok <= f_bot_ok;
        end
        if (r_s1_valid) begin
            r_w1 <= (r_s1_col == '0) ? 3'b000 : r_w2;
            r_w2 <= x_col;
        end
    end

    // Output register: load in the result state, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if ((r_state == S_RES) && (!o_out_valid || i_out_ready)) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RES) && (!o_out_valid || i_out_ready)) begin
            o_alive_out            <= r_res_read && brd_a_rd;
            o_alive_generations    <= r_res_read ? acnt_rd : '0;
            o_survived_generations <= r_res_read ? scnt_rd : '0;
        end
    end

    // Configuration register; paddr[1:0] are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_side <= BOARD_SIDE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BOARD_SIDE)) begin
            r_board_side <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BOARD_SIDE) ? 32'(r_board_side) : 32'd0;

endmodule

@@ hdl/lacc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on an address collision. No dependencies.
module lacc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read; the read sees the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ hdl/lacc_rule.sv @@
// Shared cell rule unit: neighbor sum, B3/S23 decision, saturating counters.
// Depends on lacc_pkg.
module lacc_rule import lacc_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic [2:0]             i_w1,
    input  logic [2:0]             i_w2,
    input  logic [2:0]             i_x,
    input  logic [COUNT_WIDTH-1:0] i_acnt,
    input  logic [COUNT_WIDTH-1:0] i_scnt,
    output t_rule_ctl              o_ctl,
    output logic [COUNT_WIDTH-1:0] o_acnt,
    output logic [COUNT_WIDTH-1:0] o_scnt
);

    logic [3:0] sum;
    logic       self_alive;
    logic       birth;
    logic       death;
    logic       survive;

    // Count the eight neighbors around the middle of the window
    always_comb begin
        sum = 4'(i_w1[COL_TOP]) + 4'(i_w1[COL_MID]) + 4'(i_w1[COL_BOT])
            + 4'(i_w2[COL_TOP]) + 4'(i_w2[COL_BOT])
            + 4'(i_x[COL_TOP])  + 4'(i_x[COL_MID])  + 4'(i_x[COL_BOT]);
    end

    // Apply the rule
    assign self_alive = i_w2[COL_MID];
    assign birth      = !self_alive && (sum == BIRTH_SUM);
    assign death      = self_alive && ((sum >= CROWD_SUM) || (sum <= LONELY_SUM));
    assign survive    = self_alive && !death;

    assign o_ctl.next_alive = birth || survive;
    assign o_ctl.bump_alive = birth || survive;
    assign o_ctl.bump_surv  = survive;

    // Saturate counters at all ones
    assign o_acnt = (&i_acnt) ? i_acnt : i_acnt + COUNT_WIDTH'(1);
    assign o_scnt = (&i_scnt) ? i_scnt : i_scnt + COUNT_WIDTH'(1);

endmodule

@@ hdl/lacc_checker.sv @@
// Port-level checker for the life automaton core, bound to the top level.
// Depends on the top level's port list only.
module lacc_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic                   o_alive_out,
    input logic [COUNT_WIDTH-1:0] o_alive_generations,
    input logic [COUNT_WIDTH-1:0] o_survived_generations
);

    // Reset drops the result and starts the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("result or ready seen right after reset");

    // One request at a time: ready falls after an accept
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an accepted request");

    // A live cell has been counted alive at least once
    a_alive_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alive_out) |-> (o_alive_generations != '0))
        else $error("live cell reported with zero alive count");

    // Every survival also counts as alive
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_alive_generations >= o_survived_generations))
        else $error("survival count above alive count");

    // A stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid
            && $stable({o_alive_out, o_alive_generations, o_survived_generations}))
        else $error("stalled result changed or vanished");

endmodule

bind life_automaton_with_cell_counters_core lacc_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_lacc_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_in_valid             (i_in_valid),
    .o_in_ready             (o_in_ready),
    .o_out_valid            (o_out_valid),
    .i_out_ready            (i_out_ready),
    .o_alive_out            (o_alive_out),
    .o_alive_generations    (o_alive_generations),
    .o_survived_generations (o_survived_generations)
);

@@ bench/life_automaton_with_cell_counters_core_tb.sv @@
// Testbench for life_automaton_with_cell_counters_core: directed and random requests,
// checked against an in-bench predictor of the board and its counters.
// Depends on lacc_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module life_automaton_with_cell_counters_core_tb;
    import lacc_pkg::*;

    localparam int         SIDE_LIMIT   = 64;
    localparam int         CELL_COUNT   = SIDE_LIMIT * SIDE_LIMIT;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic [2:0] ADDR_SIDE    = {REG_BOARD_SIDE, 2'b00};
    localparam logic [2:0] ADDR_SPARE   = {~REG_BOARD_SIDE, 2'b00};
    localparam logic [15:0] TALLY_TOP   = 16'hFFFF;

    typedef struct packed {
        logic        alive;
        logic [15:0] alive_gens;
        logic [15:0] survived_gens;
    } t_cell_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [5:0]  i_row;
    logic [5:0]  i_column;
    logic        i_alive_in;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_alive_out;
    logic [15:0] o_alive_generations;
    logic [15:0] o_survived_generations;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted board, counters and side register
    bit          cell_state    [0:CELL_COUNT-1];
    bit   [15:0] alive_tally   [0:CELL_COUNT-1];
    bit   [15:0] survive_tally [0:CELL_COUNT-1];
    logic [6:0]  board_side_reg = BOARD_SIDE_RESET;

    t_cell_report pending_reports [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int checked_count = 0;
    int load_count    = 0;
    int advance_count = 0;
    int read_count    = 0;
    int unused_count  = 0;

    life_automaton_with_cell_counters_core dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_mode                 (i_mode),
        .i_row                  (i_row),
        .i_column               (i_column),
        .i_alive_in             (i_alive_in),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_alive_out            (o_alive_out),
        .o_alive_generations    (o_alive_generations),
        .o_survived_generations (o_survived_generations),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #40_000_000;
        $display("Timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int effective_side();
        return (board_side_reg > SIDE_LIMIT) ? SIDE_LIMIT : int'(board_side_reg);
    endfunction

    function automatic bit [15:0] tally_bump(input bit [15:0] value);
        return (value == TALLY_TOP) ? value : value + 16'd1;
    endfunction

    // Compute one B3/S23 generation over the square in use, in row order with a line buffer
    function automatic void advance_generation();
        bit above [0:SIDE_LIMIT-1];
        bit cur   [0:SIDE_LIMIT-1];
        int n;
        int r;
        int c;
        int idx;
        int sum;
        n = effective_side();
        for (c = 0; c < SIDE_LIMIT; c++) above[c] = 1'b0;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) cur[c] = cell_state[r * SIDE_LIMIT + c];
            for (c = 0; c < n; c++) begin
                idx = r * SIDE_LIMIT + c;
                sum = above[c];
                if (c > 0) sum += above[c - 1] + cur[c - 1];
                if (c + 1 < n) sum += above[c + 1] + cur[c + 1];
                if (r + 1 < n) begin
                    sum += cell_state[idx + SIDE_LIMIT];
                    if (c > 0) sum += cell_state[idx + SIDE_LIMIT - 1];
                    if (c + 1 < n) sum += cell_state[idx + SIDE_LIMIT + 1];
                end
                if (!cur[c]) begin
                    if (sum == BIRTH_SUM) begin
                        cell_state[idx]  = 1'b1;
                        alive_tally[idx] = tally_bump(alive_tally[idx]);
                    end
                end else if (sum >= CROWD_SUM || sum <= LONELY_SUM) begin
                    cell_state[idx] = 1'b0;
                end else begin
                    alive_tally[idx]   = tally_bump(alive_tally[idx]);
                    survive_tally[idx] = tally_bump(survive_tally[idx]);
                end
            end
            for (c = 0; c < n; c++) above[c] = cur[c];
        end
    endfunction

    // Apply one request to the predicted board and return the report it produces
    function automatic t_cell_report predict_cell_report(input logic [1:0] mode,
            input logic [5:0] row, input logic [5:0] column, input logic alive);
        t_cell_report report;
        int  n;
        int  idx;
        bit  in_square;
        n         = effective_side();
        in_square = (int'(row) < n) && (int'(column) < n);
        idx       = int'(row) * SIDE_LIMIT + int'(column);
        report    = '0;
        case (mode)
            MODE_LOAD: begin
                if (in_square) begin
                    cell_state[idx]    = alive;
                    alive_tally[idx]   = {15'd0, alive};
                    survive_tally[idx] = 16'd0;
                end
            end
            MODE_ADVANCE: begin
                advance_generation();
            end
            MODE_READ: begin
                if (in_square) begin
                    report.alive         = cell_state[idx];
                    report.alive_gens    = alive_tally[idx];
                    report.survived_gens = survive_tally[idx];
                end
            end
            default: ;
        endcase
        return report;
    endfunction

    // Send one request, with a random gap first; valid stays up after acceptance
    task automatic send_request(input logic [1:0] mode, input logic [5:0] row,
            input logic [5:0] column, input logic alive);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_row      <= row;
        i_column   <= column;
        i_alive_in <= alive;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pending_reports.push_back(predict_cell_report(mode, row, column, alive));
        case (mode)
            MODE_LOAD:    load_count++;
            MODE_ADVANCE: advance_count++;
            MODE_READ:    read_count++;
            default:      unused_count++;
        endcase
    endtask

    // Drop valid and wait until every report has come back
    task automatic settle_requests(input int tail_cycles);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (tail_cycles) @(posedge i_clk);
    endtask

    // Write one register while idle, then read the side register back
    task automatic write_register(input logic [2:0] addr, input logic [6:0] value);
        logic [31:0] word;
        settle_requests(4);
        word      = $urandom();
        word[6:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr[2] == REG_BOARD_SIDE) board_side_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SIDE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== {25'd0, board_side_reg}) begin
            $display("%0t board_side read back: expected %0d, actual %0h",
                     $time, board_side_reg, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Check each accepted report against the oldest prediction, then drive ready
    always @(posedge i_clk) begin
        t_cell_report want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                $display("%0t unexpected report: alive %b alive_gens %0d survived_gens %0d",
                         $time, o_alive_out, o_alive_generations, o_survived_generations);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                checked_count++;
                if (o_alive_out !== want.alive) begin
                    $display("%0t alive_out: expected %b, actual %b",
                             $time, want.alive, o_alive_out);
                    error_count++;
                end
                if (o_alive_generations !== want.alive_gens) begin
                    $display("%0t alive_generations: expected %0d, actual %0d",
                             $time, want.alive_gens, o_alive_generations);
                    error_count++;
                end
                if (o_survived_generations !== want.survived_gens) begin
                    $display("%0t survived_generations: expected %0d, actual %0d",
                             $time, want.survived_gens, o_survived_generations);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [5:0] pick_coord(input int side);
        if ($urandom_range(99) < 85) return 6'($urandom_range(side - 1, 0));
        return 6'($urandom_range(63, 0));
    endfunction

    // Corners of the full board at the reset side, the unused mode and a full advance
    task automatic test_corners_at_reset_side();
        send_request(MODE_LOAD, 6'd0, 6'd0, 1'b1);
        send_request(MODE_LOAD, 6'd63, 6'd63, 1'b1);
        send_request(MODE_LOAD, 6'd63, 6'd0, 1'b1);
        send_request(MODE_READ, 6'd0, 6'd0, 1'b0);
        send_request(MODE_READ, 6'd5, 6'd5, 1'b1);
        send_request(MODE_UNUSED, 6'd63, 6'd63, 1'b0);
        send_request(MODE_READ, 6'd63, 6'd63, 1'b0);
        send_request(MODE_ADVANCE, 6'd63, 6'd63, 1'b1);
        send_request(MODE_READ, 6'd63, 6'd0, 1'b0);
    endtask

    // Side zero, side above the maximum, the spare address and side one
    task automatic test_side_extremes();
        write_register(ADDR_SIDE, 7'd0);
        send_request(MODE_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_request(MODE_LOAD, 6'd0, 6'd0, 1'b1);
        send_request(MODE_READ, 6'd0, 6'd0, 1'b0);
        write_register(ADDR_SIDE, 7'd127);
        write_register(ADDR_SPARE, 7'd2);
        send_request(MODE_LOAD, 6'd63, 6'd62, 1'b1);
        send_request(MODE_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_request(MODE_READ, 6'd63, 6'd63, 1'b0);
        write_register(ADDR_SIDE, 7'd1);
        send_request(MODE_LOAD, 6'd0, 6'd0, 1'b1);
        send_request(MODE_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_request(MODE_READ, 6'd0, 6'd0, 1'b0);
        send_request(MODE_READ, 6'd0, 6'd1, 1'b0);
    endtask

    // Live cells just past a shrunk border count as dead and keep their values
    task automatic test_shrunk_border();
        write_register(ADDR_SIDE, 7'd8);
        send_request(MODE_LOAD, 6'd4, 6'd2, 1'b1);
        send_request(MODE_LOAD, 6'd4, 6'd3, 1'b1);
        send_request(MODE_LOAD, 6'd4, 6'd4, 1'b1);
        write_register(ADDR_SIDE, 7'd4);
        send_request(MODE_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_request(MODE_READ, 6'd3, 6'd3, 1'b0);
        write_register(ADDR_SIDE, 7'd8);
        send_request(MODE_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_request(MODE_READ, 6'd4, 6'd3, 1'b0);
        send_request(MODE_READ, 6'd4, 6'd2, 1'b0);
    endtask

    // Hold a 2x2 block over several generations so both counters climb together
    task automatic test_still_life_counters();
        int k;
        write_register(ADDR_SIDE, 7'd2);
        send_request(MODE_LOAD, 6'd0, 6'd0, 1'b1);
        send_request(MODE_LOAD, 6'd0, 6'd1, 1'b1);
        send_request(MODE_LOAD, 6'd1, 6'd0, 1'b1);
        send_request(MODE_LOAD, 6'd1, 6'd1, 1'b1);
        for (k = 0; k < 6; k++) send_request(MODE_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_request(MODE_READ, 6'd1, 6'd1, 1'b0);
        send_request(MODE_LOAD, 6'd0, 6'd0, 1'b0);
        send_request(MODE_READ, 6'd0, 6'd0, 1'b0);
    endtask

    // Seed a small square, let it evolve, probe it; sprinkle in stray requests
    task automatic run_random_phase(input int sender_pct, input int receiver_pct,
            input int quota);
        int sent;
        int side;
        int seeds;
        int gens;
        int probes;
        int k;
        side = $urandom_range(10, 3);
        write_register(ADDR_SIDE, 7'(side));
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < quota) begin
            seeds  = $urandom_range(10, 3);
            gens   = $urandom_range(3, 1);
            probes = $urandom_range(6, 2);
            for (k = 0; k < seeds; k++)
                send_request(MODE_LOAD, pick_coord(side), pick_coord(side),
                             $urandom_range(99) < 55);
            for (k = 0; k < gens; k++)
                send_request(MODE_ADVANCE, 6'($urandom()), 6'($urandom()), 1'($urandom()));
            for (k = 0; k < probes; k++)
                send_request(MODE_READ, pick_coord(side), pick_coord(side), 1'($urandom()));
            sent += seeds + gens + probes;
            if ($urandom_range(99) < 30) begin
                send_request(MODE_UNUSED, 6'($urandom()), 6'($urandom()), 1'($urandom()));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_mode     <= MODE_LOAD;
        i_row      <= 6'd0;
        i_column   <= 6'd0;
        i_alive_in <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= ADDR_SIDE;
        pwdata     <= 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 80;
        test_corners_at_reset_side();
        test_side_extremes();
        run_random_phase(33, 80, 30);

        send_idle_pct = 80;
        recv_idle_pct = 33;
        test_shrunk_border();
        run_random_phase(80, 33, 30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_still_life_counters();
        run_random_phase(0, 0, 30);

        settle_requests(20);
        $display("Checked %0d reports: %0d loads, %0d advances, %0d reads, %0d unused-mode",
                 checked_count, load_count, advance_count, read_count, unused_count);
        $display("Sides 0, 1, 2, 4, 8, 64, 127 and random small squares; counters climbing");
        if (error_count == 0 && pending_reports.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lacc_pkg.sv
hdl/lacc_ram.sv
hdl/lacc_rule.sv
hdl/life_automaton_with_cell_counters_core.sv
hdl/lacc_checker.sv
bench/life_automaton_with_cell_counters_core_tb.sv
